### rtl/core/ttsq_pkg.sv
// Shared types, constants and elaboration-time helpers for the turn-to-heading
// sequencer. No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package ttsq_pkg;

  // Default angle format: Q16 radians.
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  // 2*pi with 24 fraction bits, the master constant for every angle format.
  localparam longint TWO_PI_24 = 64'd105414357;

  // Number of ticks spent in the reverse braking phase.
  localparam logic [7:0] BRAKE_TICKS = 8'd15;

  // Remainder steps done between two pipeline registers of the modulo unit.
  localparam int STEPS_PER_STAGE = 2;

  // Item opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Turn modes. Mode three behaves as the shorter way.
  localparam logic [1:0] MODE_CW        = 2'd0;
  localparam logic [1:0] MODE_CCW       = 2'd1;
  localparam logic [1:0] MODE_SHORT     = 2'd2;
  localparam logic [1:0] MODE_SHORT_ALT = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_RATIO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COAST_POWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HARSH_STOP  = 2'd3;

  // Configuration reset values.
  localparam logic [8:0]  FULL_RATIO_RST  = 9'd192;
  localparam logic [6:0]  COAST_POWER_RST = 7'd30;
  localparam logic [17:0] STOP_OFFSET_RST = 18'd0;
  localparam logic        HARSH_STOP_RST  = 1'b0;

  // Input item.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] heading;
    logic signed [31:0] target_angle;
    logic [1:0]         turn_mode;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              busy_res;
    logic              done_res;
  } out_item_t;

  // Fields of an item that travel down the pipeline unchanged.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] heading;
    logic [1:0]         turn_mode;
  } ctx_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [8:0]  full_ratio;
    logic [6:0]  coast_power;
    logic [17:0] stop_offset;
    logic        harsh_stop;
  } cfg_t;

  // 2*pi rounded to nearest in the given angle format.
  function automatic longint two_pi_q(input int frac);
    return (((TWO_PI_24 * 2) >>> (24 - frac)) + 1) >>> 1;
  endfunction

  // pi rounded to nearest in the given angle format.
  function automatic longint pi_q(input int frac);
    return ((TWO_PI_24 >>> (24 - frac)) + 1) >>> 1;
  endfunction

  // Bits needed for an angle in [0, 2*pi].
  function automatic int turn_width(input int frac);
    return $clog2(two_pi_q(frac));
  endfunction

  // Number of shifted subtract steps that reduce any 32-bit magnitude below c.
  function automatic int reduce_steps(input longint c);
    int n;
    n = 0;
    for (int i = 0; i < 40; i++) begin
      if ((c << i) <= 64'hFFFF_FFFF) n = i + 1;
    end
    return n;
  endfunction

  // Subtrahend c * 2^j for one remainder step.
  function automatic logic [31:0] sub_const(input longint c, input int j);
    logic [63:0] v;
    v = 64'(c) << j;
    return (j >= 0) ? v[31:0] : 32'd0;
  endfunction

  // Saturate a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] smax;
    logic signed [33:0] smin;
    smax = 34'sh0_7FFF_FFFF;
    smin = 34'sh3_8000_0000;
    if (v > smax) return 32'sh7FFF_FFFF;
    else if (v < smin) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/turn_to_heading_sequencer_core.sv
// Top level of the turn-to-heading sequencer: configuration registers and the
// modulo, planning and phase pipelines. Depends on ttsq_pkg, ttsq_reduce,
// ttsq_plan and ttsq_seq.
//
// Usage: a start item (opcode 1) gives a target angle and a turn mode; tick
// items (opcode 0) bring heading samples. Every item yields exactly one result
// item with the left and right drive commands, busy and done flags.
// Both channels use valid/stall: an item moves at a clock edge where valid is
// high and stall is low. The configuration port writes one register per cycle
// with cfg_we, cfg_index and cfg_wdata; write it only while the block is idle.
// Throughput: one item per cycle while out_stall is low. From acceptance an item
// passes the entry register and the magnitude registers of the modulo-2*pi pipeline
// (one for |diff| and one per group of the shifted subtracts that a 32-bit
// difference needs), then the planning registers and the result register.
// Every stage holds an item until the next stage is free, so bubbles close up
// and input is still taken while a result waits under out_stall; once all
// stages are full, in_stall follows out_stall in the same cycle.
// Reset (rst_n low, synchronous) empties the pipeline, puts the turn state in
// idle and loads the configuration reset values.
`default_nettype none

module turn_to_heading_sequencer_core #(
  parameter int ANGLE_FRAC_BITS = ttsq_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ttsq_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ttsq_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ttsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttsq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int TW = ttsq_pkg::turn_width(ANGLE_FRAC_BITS);

  ttsq_pkg::cfg_t     cfg_r;

  logic               red_in_ready;
  logic               red_valid;
  logic               red_ready;
  ttsq_pkg::ctx_t     red_ctx;
  logic               red_neg;
  logic [TW-1:0]      red_rem;

  logic               plan_valid;
  logic               plan_ready;
  ttsq_pkg::ctx_t     plan_ctx;
  logic               plan_cw;
  logic signed [31:0] plan_fpe;
  logic signed [31:0] plan_goal;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_ratio  <= ttsq_pkg::FULL_RATIO_RST;
      cfg_r.coast_power <= ttsq_pkg::COAST_POWER_RST;
      cfg_r.stop_offset <= ttsq_pkg::STOP_OFFSET_RST;
      cfg_r.harsh_stop  <= ttsq_pkg::HARSH_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttsq_pkg::REG_FULL_RATIO:  cfg_r.full_ratio  <= cfg_wdata[8:0];
        ttsq_pkg::REG_COAST_POWER: cfg_r.coast_power <= cfg_wdata[6:0];
        ttsq_pkg::REG_STOP_OFFSET: cfg_r.stop_offset <= cfg_wdata[17:0];
        ttsq_pkg::REG_HARSH_STOP:  cfg_r.harsh_stop  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Modulo-2*pi reduction of target minus heading.
  ttsq_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (red_in_ready),
    .in_item   (in_data),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_ctx   (red_ctx),
    .out_neg   (red_neg),
    .out_rem   (red_rem)
  );

  assign in_stall = !red_in_ready;

  // Direction, goal and end point.
  ttsq_plan #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_ctx    (red_ctx),
    .in_neg    (red_neg),
    .in_rem    (red_rem),
    .out_valid (plan_valid),
    .out_ready (plan_ready),
    .out_ctx   (plan_ctx),
    .out_cw    (plan_cw),
    .out_fpe   (plan_fpe),
    .out_goal  (plan_goal)
  );

  // Phase sequencing and result register.
  ttsq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (plan_valid),
    .in_ready  (plan_ready),
    .in_ctx    (plan_ctx),
    .in_cw     (plan_cw),
    .in_fpe    (plan_fpe),
    .in_goal   (plan_goal),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A finishing item never reports busy and always commands zero drive.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && out_data.left_drive == 8'sd0)
    else $error("done result with busy set or nonzero drive");

  // The two sides always turn against each other.
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.right_drive == -out_data.left_drive)
    else $error("right drive is not the negated left drive");

  // With the result side free, every stage moves, so the input is never held.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the result side is free");

endmodule

`default_nettype wire

### rtl/core/ttsq_reduce.sv
// Pipelined modulo unit: reduces the magnitude of target minus heading modulo 2*pi and passes its sign on.
// Depends on ttsq_pkg for types and angle constants.
`default_nettype none

module ttsq_reduce #(
  parameter int ANGLE_FRAC_BITS = ttsq_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttsq_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttsq_pkg::ctx_t        out_ctx,
  output logic                  out_neg,
  output logic [ttsq_pkg::turn_width(ANGLE_FRAC_BITS)-1:0] out_rem
);

  localparam longint CQ    = ttsq_pkg::two_pi_q(ANGLE_FRAC_BITS);
  localparam int     TW    = ttsq_pkg::turn_width(ANGLE_FRAC_BITS);
  localparam int     NSTEP = ttsq_pkg::reduce_steps(CQ);
  localparam int     SPS   = ttsq_pkg::STEPS_PER_STAGE;
  localparam int     NST   = (NSTEP + SPS - 1) / SPS;

  // Entry stage: the item and the signed 33-bit difference.
  logic                  a_v_r;
  ttsq_pkg::ctx_t        a_ctx_r;
  logic signed [32:0]    a_diff_r;
  logic signed [32:0]    a_diff_nxt;
  logic signed [32:0]    a_neg_diff;
  logic                  a_rdy;

  // Magnitude stages: stage 0 holds |diff|, stage k after k groups of steps.
  logic [NST:0]          b_v_r;
  logic [NST:0]          b_neg_r;
  ttsq_pkg::ctx_t        b_ctx_r [NST+1];
  logic [31:0]           b_mag_r [NST+1];
  logic [NST:0]          b_rdy;

  assign a_diff_nxt = 33'(in_item.target_angle) - 33'(in_item.heading);
  assign a_neg_diff = -a_diff_r;
  assign a_rdy      = !a_v_r || b_rdy[0];
  assign in_ready   = a_rdy;

  // Entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_ctx_r.opcode    <= in_item.opcode;
      a_ctx_r.heading   <= in_item.heading;
      a_ctx_r.turn_mode <= in_item.turn_mode;
      a_diff_r          <= a_diff_nxt;
    end
  end

  for (genvar k = 0; k <= NST; k++) begin : g_stage
    logic           v_in;
    logic           neg_in;
    ttsq_pkg::ctx_t ctx_in;
    logic [31:0]    mag_in;
    logic           rdy_next;

    if (k == 0) begin : g_abs
      // Magnitude of the difference; the sign is kept for the correction.
      assign v_in   = a_v_r;
      assign neg_in = a_diff_r[32];
      assign ctx_in = a_ctx_r;
      assign mag_in = a_diff_r[32] ? a_neg_diff[31:0] : a_diff_r[31:0];
    end else begin : g_sub
      localparam int BASE = NSTEP - 1 - (k - 1) * SPS;
      logic [31:0] m_c;

      // Restoring remainder steps against 2*pi shifted left by j.
      always_comb begin
        m_c = b_mag_r[k-1];
        for (int s = 0; s < SPS; s++) begin
          if (BASE - s >= 0) begin
            if (m_c >= ttsq_pkg::sub_const(CQ, BASE - s)) begin
              m_c = m_c - ttsq_pkg::sub_const(CQ, BASE - s);
            end
          end
        end
      end

      assign v_in   = b_v_r[k-1];
      assign neg_in = b_neg_r[k-1];
      assign ctx_in = b_ctx_r[k-1];
      assign mag_in = m_c;
    end

    if (k == NST) begin : g_last
      assign rdy_next = out_ready;
    end else begin : g_mid
      assign rdy_next = b_rdy[k+1];
    end

    assign b_rdy[k] = !b_v_r[k] || rdy_next;

    // Stage register.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r[k] <= 1'b0;
      end else if (b_rdy[k]) begin
        b_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (b_rdy[k] && v_in) begin
        b_neg_r[k] <= neg_in;
        b_ctx_r[k] <= ctx_in;
        b_mag_r[k] <= mag_in;
      end
    end
  end

  assign out_valid = b_v_r[NST];
  assign out_ctx   = b_ctx_r[NST];
  assign out_neg   = b_neg_r[NST];
  assign out_rem   = b_mag_r[NST][TW-1:0];

endmodule

`default_nettype wire

### rtl/core/ttsq_plan.sv
// Turn planning pipeline: direction, turn size, goal and full-power end point.
// Depends on ttsq_pkg; fed by ttsq_reduce.
`default_nettype none

module ttsq_plan #(
  parameter int ANGLE_FRAC_BITS = ttsq_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ttsq_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ttsq_pkg::ctx_t            in_ctx,
  input  logic                      in_neg,
  input  logic [ttsq_pkg::turn_width(ANGLE_FRAC_BITS)-1:0] in_rem,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ttsq_pkg::ctx_t            out_ctx,
  output logic                      out_cw,
  output logic signed [31:0]        out_fpe,
  output logic signed [31:0]        out_goal
);

  localparam int TW = ttsq_pkg::turn_width(ANGLE_FRAC_BITS);
  localparam logic [TW-1:0] C_T  = TW'(ttsq_pkg::two_pi_q(ANGLE_FRAC_BITS));
  localparam logic [TW-1:0] PI_T = TW'(ttsq_pkg::pi_q(ANGLE_FRAC_BITS));

  // Stage 0: the chosen direction and the wrapped turn in that direction.
  logic               p0_v_r;
  ttsq_pkg::ctx_t     p0_ctx_r;
  logic               p0_cw_r;
  logic [TW-1:0]      p0_turn_r;
  logic               p0_rdy;
  logic [TW-1:0]      c_minus;
  logic               rem_nz;
  logic [TW-1:0]      cw_turn;
  logic [TW-1:0]      ccw_turn;
  logic               p0_cw_nxt;
  logic [TW-1:0]      p0_turn_nxt;

  // Stage 1: scaled turn for the full-power end point.
  logic               p1_v_r;
  ttsq_pkg::ctx_t     p1_ctx_r;
  logic               p1_cw_r;
  logic [TW-1:0]      p1_turn_r;
  logic [TW:0]        p1_scaled_r;
  logic               p1_rdy;
  logic [TW+8:0]      prod;

  // Stage 2: saturated goal and end point.
  logic               p2_v_r;
  ttsq_pkg::ctx_t     p2_ctx_r;
  logic               p2_cw_r;
  logic signed [31:0] p2_goal_r;
  logic signed [31:0] p2_fpe_r;
  logic               p2_rdy;
  logic signed [33:0] h34;
  logic signed [33:0] turn34;
  logic signed [33:0] scaled34;
  logic signed [33:0] goal_sum;
  logic signed [33:0] fpe_sum;

  assign p2_rdy   = !p2_v_r || out_ready;
  assign p1_rdy   = !p1_v_r || p2_rdy;
  assign p0_rdy   = !p0_v_r || p1_rdy;
  assign in_ready = p0_rdy;

  // Both wrapped differences come from one remainder and its complement.
  assign c_minus  = C_T - in_rem;
  assign rem_nz   = (in_rem != '0);
  assign cw_turn  = (in_neg && rem_nz) ? c_minus : in_rem;
  assign ccw_turn = (!in_neg && rem_nz) ? c_minus : in_rem;

  always_comb begin
    case (in_ctx.turn_mode)
      ttsq_pkg::MODE_CW:  p0_cw_nxt = 1'b1;
      ttsq_pkg::MODE_CCW: p0_cw_nxt = 1'b0;
      default:            p0_cw_nxt = !(cw_turn > PI_T);
    endcase
    p0_turn_nxt = p0_cw_nxt ? cw_turn : ccw_turn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (p0_rdy) begin
      p0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p0_rdy && in_valid) begin
      p0_ctx_r  <= in_ctx;
      p0_cw_r   <= p0_cw_nxt;
      p0_turn_r <= p0_turn_nxt;
    end
  end

  // Turn times full_ratio, Q8 result floored.
  assign prod = (TW+9)'(p0_turn_r) * (TW+9)'(cfg.full_ratio);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_r <= p0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && p0_v_r) begin
      p1_ctx_r    <= p0_ctx_r;
      p1_cw_r     <= p0_cw_r;
      p1_turn_r   <= p0_turn_r;
      p1_scaled_r <= prod[TW+8:8];
    end
  end

  // Goal and end point on the side of the chosen direction.
  assign h34      = 34'(p1_ctx_r.heading);
  assign turn34   = $signed(34'(p1_turn_r));
  assign scaled34 = $signed(34'(p1_scaled_r));
  assign goal_sum = p1_cw_r ? (h34 + turn34) : (h34 - turn34);
  assign fpe_sum  = p1_cw_r ? (h34 + scaled34) : (h34 - scaled34);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_v_r) begin
      p2_ctx_r  <= p1_ctx_r;
      p2_cw_r   <= p1_cw_r;
      p2_goal_r <= ttsq_pkg::sat32(goal_sum);
      p2_fpe_r  <= ttsq_pkg::sat32(fpe_sum);
    end
  end

  assign out_valid = p2_v_r;
  assign out_ctx   = p2_ctx_r;
  assign out_cw    = p2_cw_r;
  assign out_fpe   = p2_fpe_r;
  assign out_goal  = p2_goal_r;

endmodule

`default_nettype wire

### rtl/core/ttsq_seq.sv
// Turn phase sequencer and result register: holds the turn state and builds
// the drive command for each item. Depends on ttsq_pkg; fed by ttsq_plan.
`default_nettype none

module ttsq_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttsq_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttsq_pkg::ctx_t       in_ctx,
  input  logic                 in_cw,
  input  logic signed [31:0]   in_fpe,
  input  logic signed [31:0]   in_goal,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ttsq_pkg::out_item_t  out_data
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FULL  = 2'd1;
  localparam logic [1:0] PH_COAST = 2'd2;
  localparam logic [1:0] PH_BRAKE = 2'd3;

  // Turn state.
  logic [1:0]          phase_r;
  logic [1:0]          phase_nxt;
  logic                cw_r;
  logic                cw_nxt;
  logic signed [31:0]  fpe_r;
  logic signed [31:0]  fpe_nxt;
  logic signed [31:0]  goal_r;
  logic signed [31:0]  goal_nxt;
  logic [7:0]          brake_cnt_r;
  logic [7:0]          brake_cnt_nxt;

  // Result register.
  logic                out_v_r;
  ttsq_pkg::out_item_t out_r;
  ttsq_pkg::out_item_t out_nxt;

  logic                take;
  logic                idle_tick;
  logic                finish;
  logic signed [32:0]  h33;
  logic signed [32:0]  off33;
  logic signed [32:0]  thr_c;
  logic signed [7:0]   coast_drv;
  logic signed [7:0]   left_c;

  assign in_ready = !out_v_r || !out_stall;
  assign take     = in_valid && in_ready;
  assign h33      = 33'(in_ctx.heading);
  assign off33    = $signed({15'd0, cfg.stop_offset});
  assign coast_drv = $signed({1'b0, cfg.coast_power});

  // Phase checks in order: start, full, brake countdown, coast.
  always_comb begin
    phase_nxt     = phase_r;
    cw_nxt        = cw_r;
    fpe_nxt       = fpe_r;
    goal_nxt      = goal_r;
    brake_cnt_nxt = brake_cnt_r;
    idle_tick     = 1'b0;
    finish        = 1'b0;
    thr_c         = '0;

    if (in_ctx.opcode == ttsq_pkg::OP_START) begin
      phase_nxt = PH_FULL;
      cw_nxt    = in_cw;
      fpe_nxt   = in_fpe;
      goal_nxt  = in_goal;
    end else if (phase_r == PH_IDLE) begin
      idle_tick = 1'b1;
    end

    if (!idle_tick) begin
      if (phase_nxt == PH_FULL) begin
        if (!(cw_nxt ? (in_ctx.heading < fpe_nxt) : (in_ctx.heading > fpe_nxt))) begin
          phase_nxt = PH_COAST;
        end
      end else if (phase_nxt == PH_BRAKE) begin
        brake_cnt_nxt = brake_cnt_nxt - 8'd1;
        if (brake_cnt_nxt == 8'd0) begin
          phase_nxt = PH_IDLE;
          finish    = 1'b1;
        end
      end

      // The coast threshold uses the stop offset in force for this item.
      if (phase_nxt == PH_COAST) begin
        thr_c = cw_nxt ? (33'(goal_nxt) - off33) : (33'(goal_nxt) + off33);
        if (!(cw_nxt ? (h33 < thr_c) : (h33 > thr_c))) begin
          if (cfg.harsh_stop) begin
            phase_nxt     = PH_BRAKE;
            brake_cnt_nxt = ttsq_pkg::BRAKE_TICKS;
          end else begin
            phase_nxt = PH_IDLE;
            finish    = 1'b1;
          end
        end
      end
    end
  end

  // Drive command for the phase the item leaves the block in.
  always_comb begin
    unique case (phase_nxt)
      PH_FULL:  left_c = cw_nxt ? 8'sd127 : -8'sd127;
      PH_COAST: left_c = cw_nxt ? coast_drv : -coast_drv;
      PH_BRAKE: left_c = cw_nxt ? -8'sd20 : 8'sd20;
      default:  left_c = 8'sd0;
    endcase
    if (idle_tick || finish) begin
      left_c = 8'sd0;
    end
    out_nxt.left_drive  = left_c;
    out_nxt.right_drive = -left_c;
    out_nxt.busy_res    = !(idle_tick || finish);
    out_nxt.done_res    = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cw_r        <= 1'b0;
      brake_cnt_r <= 8'd0;
      out_v_r     <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        cw_r        <= cw_nxt;
        brake_cnt_r <= brake_cnt_nxt;
      end
      if (in_ready) begin
        out_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fpe_r  <= fpe_nxt;
      goal_r <= goal_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### bench/tb_turn_to_heading_sequencer_core.sv
`timescale 1ns / 1ps
// Self-checking bench for turn_to_heading_sequencer_core: a scoreboard that predicts
// every drive command, random start and tick items, and several register settings.
// Depends on ttsq_pkg and the core RTL.

package tb_turn_seq_pkg;

  // Angle constants in Q16, rounded to nearest from the 24-fraction-bit value.
  localparam longint TURN_TWO_PI = (((ttsq_pkg::TWO_PI_24 * 2) >>> 8) + 1) >>> 1;
  localparam longint TURN_PI = ((ttsq_pkg::TWO_PI_24 >>> 8) + 1) >>> 1;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {TURN_IDLE, TURN_FULL, TURN_COAST, TURN_BRAKE} turn_phase_t;

  // Positive remainder modulo one full turn.
  function automatic longint wrap_angle(input longint d);
    longint r;
    r = d % TURN_TWO_PI;
    if (r < 0) r = r + TURN_TWO_PI;
    return r;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Tracks the turn state, predicts one drive command per item and checks results.
  class heading_scoreboard;
    turn_phase_t         phase;
    bit                  clockwise;
    longint              goal_heading;
    longint              full_end;
    int                  brake_left;
    int                  full_ratio;
    int                  coast_power;
    int                  stop_offset;
    bit                  harsh_stop;
    ttsq_pkg::out_item_t pending[$];
    int                  errors;
    int                  items;
    int                  results;
    int                  turns_done;

    function void reset_state();
      phase        = TURN_IDLE;
      clockwise    = 1'b0;
      goal_heading = 0;
      full_end     = 0;
      brake_left   = 0;
      full_ratio   = int'(ttsq_pkg::FULL_RATIO_RST);
      coast_power  = int'(ttsq_pkg::COAST_POWER_RST);
      stop_offset  = int'(ttsq_pkg::STOP_OFFSET_RST);
      harsh_stop   = ttsq_pkg::HARSH_STOP_RST;
    endfunction

    function void set_reg(input logic [ttsq_pkg::CFG_IDX_W-1:0] idx,
                          input logic [ttsq_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ttsq_pkg::REG_FULL_RATIO:  full_ratio = int'(val[8:0]);
        ttsq_pkg::REG_COAST_POWER: coast_power = int'(val[6:0]);
        ttsq_pkg::REG_STOP_OFFSET: stop_offset = int'(val[17:0]);
        ttsq_pkg::REG_HARSH_STOP:  harsh_stop = val[0];
        default: ;
      endcase
    endfunction

    function ttsq_pkg::out_item_t drive_cmd(input int left, input bit busy, input bit done);
      ttsq_pkg::out_item_t r;
      int                  right;
      right = -left;
      r.left_drive  = left[7:0];
      r.right_drive = right[7:0];
      r.busy_res    = busy;
      r.done_res    = done;
      return r;
    endfunction

    // Advance the turn state by one item and return the drive command it yields.
    function ttsq_pkg::out_item_t step_turn(input ttsq_pkg::in_item_t it);
      longint h;
      longint t;
      longint turn;
      bit     hold;
      int     sgn;
      h = longint'($signed(it.heading));
      if (it.opcode == ttsq_pkg::OP_START) begin
        t = longint'($signed(it.target_angle));
        if (it.turn_mode == ttsq_pkg::MODE_CW) clockwise = 1'b1;
        else if (it.turn_mode == ttsq_pkg::MODE_CCW) clockwise = 1'b0;
        else clockwise = !(wrap_angle(t - h) > TURN_PI);
        if (clockwise) begin
          turn         = wrap_angle(t - h);
          goal_heading = clamp32(h + turn);
          full_end     = clamp32(h + ((turn * full_ratio) >>> 8));
        end else begin
          turn         = wrap_angle(h - t);
          goal_heading = clamp32(h - turn);
          full_end     = clamp32(h - ((turn * full_ratio) >>> 8));
        end
        phase = TURN_FULL;
      end else if (phase == TURN_IDLE) begin
        return drive_cmd(0, 1'b0, 1'b0);
      end

      if (phase == TURN_FULL) begin
        hold = clockwise ? (h < full_end) : (h > full_end);
        if (!hold) phase = TURN_COAST;
      end else if (phase == TURN_BRAKE) begin
        brake_left = (brake_left - 1) & 255;
        if (brake_left == 0) begin
          phase = TURN_IDLE;
          return drive_cmd(0, 1'b0, 1'b1);
        end
      end

      // Coast ends at the goal, short of it by the stop margin.
      if (phase == TURN_COAST) begin
        hold = clockwise ? (h < goal_heading - stop_offset) : (h > goal_heading + stop_offset);
        if (!hold) begin
          if (harsh_stop) begin
            phase      = TURN_BRAKE;
            brake_left = int'(ttsq_pkg::BRAKE_TICKS);
          end else begin
            phase = TURN_IDLE;
            return drive_cmd(0, 1'b0, 1'b1);
          end
        end
      end

      sgn = clockwise ? 1 : -1;
      if (phase == TURN_FULL) return drive_cmd(127 * sgn, 1'b1, 1'b0);
      if (phase == TURN_COAST) return drive_cmd(coast_power * sgn, 1'b1, 1'b0);
      return drive_cmd(-20 * sgn, 1'b1, 1'b0);
    endfunction

    function void note_item(input ttsq_pkg::in_item_t it);
      items++;
      pending.push_back(step_turn(it));
    endfunction

    task report(input string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(input ttsq_pkg::out_item_t got);
      ttsq_pkg::out_item_t want;
      results++;
      if (got.done_res === 1'b1) turns_done++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with no item outstanding", results));
      end else begin
        want = pending.pop_front();
        if (got.left_drive !== want.left_drive)
          report($sformatf("result %0d left_drive %0d, expected %0d",
                           results, got.left_drive, want.left_drive));
        if (got.right_drive !== want.right_drive)
          report($sformatf("result %0d right_drive %0d, expected %0d",
                           results, got.right_drive, want.right_drive));
        if (got.busy_res !== want.busy_res)
          report($sformatf("result %0d busy_res %b, expected %b",
                           results, got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report($sformatf("result %0d done_res %b, expected %b",
                           results, got.done_res, want.done_res));
      end
    endtask
  endclass
endpackage

module tb_turn_to_heading_sequencer_core;

  localparam int IW = ttsq_pkg::CFG_IDX_W;
  localparam int DW = ttsq_pkg::CFG_DATA_W;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ttsq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ttsq_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [IW-1:0]       cfg_index = '0;
  logic [DW-1:0]       cfg_wdata = '0;

  tb_turn_seq_pkg::heading_scoreboard sb;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  settings_used = 1;
  int  stall_tick = 0;
  int  stall_style = 0;

  turn_to_heading_sequencer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // The receiver switches at random between stall styles.
  always @(negedge clk) begin
    stall_tick = stall_tick + 1;
    if (stall_tick % 300 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ((stall_tick % 11) < 4);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  function automatic ttsq_pkg::in_item_t tick_item(input longint h);
    ttsq_pkg::in_item_t it;
    it.opcode       = ttsq_pkg::OP_TICK;
    it.heading      = h[31:0];
    it.target_angle = $urandom();
    it.turn_mode    = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic ttsq_pkg::in_item_t start_item(input longint h, input longint t,
                                                    input logic [1:0] mode);
    ttsq_pkg::in_item_t it;
    it.opcode       = ttsq_pkg::OP_START;
    it.heading      = h[31:0];
    it.target_angle = t[31:0];
    it.turn_mode    = mode;
    return it;
  endfunction

  task idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Present one item and hold it until the block takes it.
  task send_item(input ttsq_pkg::in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
  endtask

  // Sender works in bursts, with gaps between them while gaps_on is set.
  task push_item(input ttsq_pkg::in_item_t it);
    if (burst_left == 0) begin
      if (gaps_on) idle_sender(($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                           : $urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(it);
  endtask

  // Hold off input until every outstanding item has produced its result.
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task write_reg(input logic [IW-1:0] idx, input int val, input int width);
    logic [DW-1:0] data;
    data = DW'(val);
    if ($urandom_range(0, 1)) data = data | (DW'($urandom()) << width);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task apply_setting(input int ratio, input int coast, input int offset, input bit harsh);
    drain();
    write_reg(ttsq_pkg::REG_FULL_RATIO, ratio, 9);
    write_reg(ttsq_pkg::REG_COAST_POWER, coast, 7);
    write_reg(ttsq_pkg::REG_STOP_OFFSET, offset, 18);
    write_reg(ttsq_pkg::REG_HARSH_STOP, int'(harsh), 1);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One turn: a start, then headings moving the chosen way, sometimes cut short.
  task run_turn();
    longint     h;
    longint     t;
    longint     pos;
    logic [1:0] mode;
    longint     dir;
    int         n;
    if ($urandom_range(0, 9) == 0) h = longint'(int'($urandom()));
    else h = longint'($urandom_range(0, 2000000)) - 1000000;
    if ($urandom_range(0, 7) == 0) t = longint'(int'($urandom()));
    else t = tb_turn_seq_pkg::clamp32(h + longint'($urandom_range(0, 900000)) - 450000);
    mode = 2'($urandom_range(0, 3));
    if (mode == ttsq_pkg::MODE_CW) dir = 1;
    else if (mode == ttsq_pkg::MODE_CCW) dir = -1;
    else dir = (tb_turn_seq_pkg::wrap_angle(t - h) > tb_turn_seq_pkg::TURN_PI) ? -1 : 1;
    push_item(start_item(h, t, mode));
    pos = h;
    n = $urandom_range(10, 45);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) return;
      if ($urandom_range(0, 11) == 0) pos = pos - dir * longint'($urandom_range(0, 3000));
      else pos = pos + dir * longint'($urandom_range(1000, 25000));
      push_item(tick_item(pos));
    end
    // Extra ticks let a braking phase run out.
    repeat ($urandom_range(0, 18)) begin
      pos = pos + dir * longint'($urandom_range(0, 40000));
      push_item(tick_item(pos));
    end
  endtask

  task noise_items();
    ttsq_pkg::in_item_t it;
    repeat ($urandom_range(1, 5)) begin
      it.opcode       = 1'($urandom_range(0, 1));
      it.heading      = $urandom();
      it.target_angle = $urandom();
      it.turn_mode    = 2'($urandom_range(0, 3));
      push_item(it);
    end
  endtask

  task random_phase(input int quota);
    int goal_items;
    goal_items = sb.items + quota;
    gaps_on = ($urandom_range(0, 3) != 0);
    while (sb.items < goal_items) begin
      if ($urandom_range(0, 6) == 0) noise_items();
      else run_turn();
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  // Corner items under the reset register values.
  task directed();
    longint s_max;
    longint s_min;
    longint t_pi;
    s_max = tb_turn_seq_pkg::S32_MAX;
    s_min = tb_turn_seq_pkg::S32_MIN;
    t_pi  = tb_turn_seq_pkg::TURN_PI;
    push_item(tick_item(0));
    push_item(tick_item(s_max));
    push_item(tick_item(s_min));
    push_item(start_item(1000, 1000, ttsq_pkg::MODE_CW));
    push_item(start_item(0, t_pi, ttsq_pkg::MODE_SHORT));
    push_item(tick_item(100000));
    push_item(tick_item(160000));
    push_item(tick_item(t_pi));
    push_item(start_item(0, t_pi + 1, ttsq_pkg::MODE_SHORT));
    push_item(tick_item(-300000));
    push_item(start_item(-50, s_min, ttsq_pkg::MODE_SHORT_ALT));
    push_item(tick_item(-60));
    push_item(start_item(s_max - 10, s_min, ttsq_pkg::MODE_CW));
    push_item(tick_item(s_max - 5));
    push_item(tick_item(s_max));
    push_item(start_item(s_min + 5, s_max, ttsq_pkg::MODE_CCW));
    push_item(tick_item(s_min));
    push_item(start_item(0, 0, ttsq_pkg::MODE_CCW));
    push_item(start_item(0, -1, ttsq_pkg::MODE_CW));
    push_item(tick_item(tb_turn_seq_pkg::TURN_TWO_PI));
    push_item(tick_item(0));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed();
    random_phase(200);
    apply_setting(0, 0, 0, 1'b1);
    random_phase(200);
    apply_setting(256, 127, 205887, 1'b0);
    random_phase(200);
    apply_setting(511, 127, 262143, 1'b1);
    random_phase(150);
    apply_setting(128, 64, 1000, 1'b1);
    random_phase(200);
    apply_setting($urandom_range(0, 256), $urandom_range(0, 127),
                  $urandom_range(0, 205887), 1'($urandom_range(0, 1)));
    random_phase(200);

    drain();
    repeat (30) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    $display("Covered %0d items and %0d results over %0d register settings;",
             sb.items, sb.results, settings_used);
    $display("%0d turns ran to completion, %0d mismatches seen.", sb.turns_done, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
